FILE: rtl/core/ssng_pkg.sv
// shared types and constants of the step sequencer note generator
package ssng_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_PITCH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_LEN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_NOTES    = 3'd4;

    // result status codes
    localparam logic [1:0] STATUS_NOTE   = 2'd0;
    localparam logic [1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;

    // fixed limits
    localparam int MAX_STEPS_PER_ITEM = 16;
    localparam logic [4:0] PATTERN_LEN = 5'd16;
    localparam logic [6:0] RESULT_CAP  = 7'd64;
    localparam logic [8:0] GATE_MIN    = 9'd13;
    localparam logic [8:0] GATE_MAX    = 9'd256;

    // reset values of the registers
    localparam logic [15:0] PATTERN_MASK_RST = 16'h1111;
    localparam logic [6:0]  NOTE_PITCH_RST   = 7'd60;
    localparam logic [8:0]  GATE_LEN_RST     = 9'd192;
    localparam logic [4:0]  STEP_COUNT_RST   = 5'd16;
    localparam logic [6:0]  MAX_NOTES_RST    = 7'd64;

    // sequencer states
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_PREP   = 9'b000000010,
        S_CHECK  = 9'b000000100,
        S_MOD    = 9'b000001000,
        S_OFF0   = 9'b000010000,
        S_STEP   = 9'b000100000,
        S_PAT    = 9'b001000000,
        S_OFF1   = 9'b010000000,
        S_FINISH = 9'b100000000
    } seq_state_t;

endpackage

FILE: rtl/core/step_sequencer_note_gen_core.sv
// step sequencer note generator: walks the steps of one beat range and emits note events
//
//  channel   | dir | ports                          | contents
//  ----------+-----+--------------------------------+------------------------------------
//  beats in  | in  | s_tvalid s_tready s_tdata      | beat_start, beat_end (signed)
//  events out| out | m_tvalid m_tready m_tdata      | event_pitch, is_note_on; tlast=last,
//            |     | m_tlast m_tuser                | tuser=status
//  config    | in  | cfg_wr_en cfg_index cfg_wdata  | register writes, no read-back
//
// KW = 35 - FRAC_BITS (19 at the default) is the width of a step number; a step already
// emitted by the previous range is skipped without a new event; the remainder of the first
// step by the step count is found one bit per cycle and the step walk shares one compare
// and add path
// a rejected or zero-note item skips the step walk and goes straight to its final result
// reset (aresetn low, synchronous) restores the register defaults and clears the note state
// a stalled result holds the walk only when a new event must be pushed; the next item is taken
// while the final result of the last one still waits in the output register
module step_sequencer_note_gen_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] beat_start, [63:32] beat_end

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] event_pitch, [7] is_note_on
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // [1:0] status

    input  logic                           cfg_wr_en,
    input  logic [ssng_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ssng_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // step numbers: ceil(beat*4 / 2^FRAC_BITS) spans 35 - FRAC_BITS signed bits
    localparam int KW   = 35 - FRAC_BITS;
    localparam int CMPW = KW + FRAC_BITS;       // beat compare width
    localparam int XW   = CMPW - 32;
    localparam int BCW  = $clog2(KW);
    localparam int SHL  = (FRAC_BITS >= 10) ? FRAC_BITS - 10 : 0;
    localparam int SHR  = (FRAC_BITS < 10) ? 10 - FRAC_BITS : 0;
    localparam int VX   = KW + 9;
    localparam int VW   = VX + SHL;

    // configuration registers
    logic [15:0] pattern_mask_reg;
    logic [6:0]  note_pitch_reg;
    logic [8:0]  gate_len_reg;
    logic [4:0]  step_count_reg;
    logic [6:0]  max_notes_reg;

    // sequencer and item registers
    ssng_pkg::seq_state_t state_reg, state_next;
    logic signed [31:0]   bstart_reg, bstart_next;
    logic signed [31:0]   bend_reg, bend_next;
    logic signed [KW-1:0] k_reg, k_next;
    logic signed [KW-1:0] lastk_reg, lastk_next;
    logic [3:0]           idx_reg, idx_next;
    logic [BCW-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [6:0]           ocount_reg, ocount_next;
    logic [1:0]           fin_status_reg, fin_status_next;

    // one event held back so the final one can carry last
    logic       pend_valid_reg, pend_valid_next;
    logic [6:0] pend_pitch_reg, pend_pitch_next;
    logic       pend_on_reg, pend_on_next;

    // note state kept across items
    logic                 sounding_reg, sounding_next;
    logic signed [31:0]   off_time_reg, off_time_next;
    logic [6:0]           sounding_pitch_reg, sounding_pitch_next;
    logic                 prev_valid_reg, prev_valid_next;
    logic signed [KW-1:0] prev_step_reg, prev_step_next;

    // output register
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tlast_reg, m_tlast_next;
    logic [1:0] m_tuser_reg, m_tuser_next;

    // clamped configuration
    logic [4:0] steps_c;
    logic [8:0] gate_c;
    logic [6:0] cap_c;

    // datapath
    logic signed [CMPW-1:0] start_sum, end_sum, start_sh, end_sh;
    logic signed [KW-1:0]   first_k, end_k;
    logic signed [KW+1:0]   span;
    logic signed [CMPW-1:0] off_ext, bstart_ext, bend_ext, at_ext, limit_ext;
    logic                   off_due;
    logic [4:0]             rem_sh, rem_red, idx_inc;
    logic [3:0]             idx_adv;
    logic signed [KW-1:0]   k_inc;
    logic                   more_steps;
    logic [VX-1:0]          gate_sum;
    logic [VW-1:0]          off_wide;
    logic [31:0]            off_new;
    logic                   pat_bit;

    // event push
    logic       emit_req, emit_on, do_emit, stall, can_push;
    logic [6:0] emit_pitch;

    always_comb begin
        if (step_count_reg == 5'd0) begin
            steps_c = 5'd1;
        end else if (step_count_reg > ssng_pkg::PATTERN_LEN) begin
            steps_c = ssng_pkg::PATTERN_LEN;
        end else begin
            steps_c = step_count_reg;
        end
        if (gate_len_reg < ssng_pkg::GATE_MIN) begin
            gate_c = ssng_pkg::GATE_MIN;
        end else if (gate_len_reg > ssng_pkg::GATE_MAX) begin
            gate_c = ssng_pkg::GATE_MAX;
        end else begin
            gate_c = gate_len_reg;
        end
        cap_c = (max_notes_reg > ssng_pkg::RESULT_CAP) ? ssng_pkg::RESULT_CAP : max_notes_reg;
    end

    // ceil of beat*4 / 2^FRAC_BITS for both range ends
    always_comb begin
        start_sum = $signed({bstart_reg[31], bstart_reg, 2'b00})
                  + $signed({{KW{1'b0}}, {FRAC_BITS{1'b1}}});
        end_sum   = $signed({bend_reg[31], bend_reg, 2'b00})
                  + $signed({{KW{1'b0}}, {FRAC_BITS{1'b1}}});
        start_sh  = start_sum >>> FRAC_BITS;
        end_sh    = end_sum >>> FRAC_BITS;
        first_k   = start_sh[KW-1] ? '0 : start_sh[KW-1:0];
        end_k     = end_sh[KW-1:0] - KW'(1);
        span      = {{2{lastk_reg[KW-1]}}, lastk_reg} - {{2{k_reg[KW-1]}}, k_reg}
                  + (KW+2)'(1);
    end

    // gated note-off check against range end or current step time
    always_comb begin
        off_ext    = {{XW{off_time_reg[31]}}, off_time_reg};
        bstart_ext = {{XW{bstart_reg[31]}}, bstart_reg};
        bend_ext   = {{XW{bend_reg[31]}}, bend_reg};
        at_ext     = $signed({{FRAC_BITS{k_reg[KW-1]}}, k_reg}) <<< (FRAC_BITS - 2);
        limit_ext  = (state_reg == ssng_pkg::S_STEP) ? at_ext : bend_ext;
        off_due    = sounding_reg && (off_ext > bstart_ext) && (off_ext <= limit_ext);
    end

    // step index, remainder bit step and off time of a new note
    always_comb begin
        rem_sh     = {idx_reg, k_reg[bit_cnt_reg]};
        rem_red    = (rem_sh >= steps_c) ? rem_sh - steps_c : rem_sh;
        idx_inc    = {1'b0, idx_reg} + 5'd1;
        idx_adv    = (idx_inc == steps_c) ? 4'd0 : idx_inc[3:0];
        k_inc      = k_reg + KW'(1);
        more_steps = (k_inc <= lastk_reg);
        gate_sum   = VX'({k_reg[KW-2:0], 8'h00}) + VX'(gate_c);
        off_wide   = (VW'(gate_sum) << SHL) >> SHR;
        off_new    = (off_wide > VW'(32'h7fff_ffff)) ? 32'h7fff_ffff : off_wide[31:0];
        pat_bit    = pattern_mask_reg[idx_reg];
    end

    assign can_push = !m_tvalid_reg || m_tready;

    // which event the current state wants to push
    always_comb begin
        emit_req   = 1'b0;
        emit_on    = 1'b0;
        emit_pitch = sounding_pitch_reg;
        unique case (state_reg) inside
            ssng_pkg::S_OFF0, ssng_pkg::S_OFF1, ssng_pkg::S_STEP: begin
                emit_req = off_due && !(state_reg == ssng_pkg::S_STEP && prev_valid_reg
                                        && prev_step_reg == k_reg);
            end
            ssng_pkg::S_PAT: begin
                emit_req = pat_bit;
                if (!sounding_reg) begin
                    emit_on    = 1'b1;
                    emit_pitch = note_pitch_reg;
                end
            end
            default: begin
                emit_req = 1'b0;
            end
        endcase
        do_emit = emit_req && (ocount_reg < cap_c);
        // only a push into a busy output register holds the walk
        stall   = do_emit && pend_valid_reg && !can_push;
    end

    always_comb begin
        state_next          = state_reg;
        bstart_next         = bstart_reg;
        bend_next           = bend_reg;
        k_next              = k_reg;
        lastk_next          = lastk_reg;
        idx_next            = idx_reg;
        bit_cnt_next        = bit_cnt_reg;
        ocount_next         = ocount_reg;
        fin_status_next     = fin_status_reg;
        pend_valid_next     = pend_valid_reg;
        pend_pitch_next     = pend_pitch_reg;
        pend_on_next        = pend_on_reg;
        sounding_next       = sounding_reg;
        off_time_next       = off_time_reg;
        sounding_pitch_next = sounding_pitch_reg;
        prev_valid_next     = prev_valid_reg;
        prev_step_next      = prev_step_reg;
        m_tvalid_next       = m_tvalid_reg && !m_tready;
        m_tdata_next        = m_tdata_reg;
        m_tlast_next        = m_tlast_reg;
        m_tuser_next        = m_tuser_reg;

        // push: the held event goes out, the new one is held
        if (do_emit && !stall) begin
            if (pend_valid_reg) begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = {pend_on_reg, pend_pitch_reg};
                m_tlast_next  = 1'b0;
                m_tuser_next  = ssng_pkg::STATUS_NOTE;
            end
            pend_valid_next = 1'b1;
            pend_pitch_next = emit_pitch;
            pend_on_next    = emit_on;
            ocount_next     = ocount_reg + 7'd1;
        end

        unique case (state_reg)
            ssng_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    bstart_next     = s_tdata[31:0];
                    bend_next       = s_tdata[63:32];
                    ocount_next     = '0;
                    pend_valid_next = 1'b0;
                    fin_status_next = ssng_pkg::STATUS_EMPTY;
                    state_next      = ssng_pkg::S_PREP;
                end
            end
            ssng_pkg::S_PREP: begin
                k_next     = first_k;
                lastk_next = end_k;
                state_next = ssng_pkg::S_CHECK;
            end
            ssng_pkg::S_CHECK: begin
                idx_next     = '0;
                bit_cnt_next = BCW'(KW - 1);
                if (max_notes_reg == 7'd0) begin
                    state_next = ssng_pkg::S_FINISH;
                end else if (span > (KW+2)'(ssng_pkg::MAX_STEPS_PER_ITEM)) begin
                    fin_status_next = ssng_pkg::STATUS_REJECT;
                    state_next      = ssng_pkg::S_FINISH;
                end else begin
                    state_next = ssng_pkg::S_MOD;
                end
            end
            ssng_pkg::S_MOD: begin
                // restoring remainder of the first step by the step count, msb first
                idx_next     = rem_red[3:0];
                bit_cnt_next = bit_cnt_reg - BCW'(1);
                if (bit_cnt_reg == '0) begin
                    state_next = ssng_pkg::S_OFF0;
                end
            end
            ssng_pkg::S_OFF0: begin
                if (!stall) begin
                    if (off_due) begin
                        sounding_next = 1'b0;
                    end
                    state_next = (k_reg <= lastk_reg) ? ssng_pkg::S_STEP : ssng_pkg::S_OFF1;
                end
            end
            ssng_pkg::S_STEP: begin
                if (prev_valid_reg && prev_step_reg == k_reg) begin
                    // step already emitted by the previous range
                    k_next     = k_inc;
                    idx_next   = idx_adv;
                    state_next = more_steps ? ssng_pkg::S_STEP : ssng_pkg::S_OFF1;
                end else if (!stall) begin
                    prev_valid_next = 1'b1;
                    prev_step_next  = k_reg;
                    if (off_due) begin
                        sounding_next = 1'b0;
                    end
                    state_next = ssng_pkg::S_PAT;
                end
            end
            ssng_pkg::S_PAT: begin
                if (!stall) begin
                    if (pat_bit && sounding_reg) begin
                        // end the sounding note, start the new one when this state runs again
                        sounding_next = 1'b0;
                    end else begin
                        if (pat_bit) begin
                            sounding_next       = 1'b1;
                            sounding_pitch_next = note_pitch_reg;
                            off_time_next       = off_new;
                        end
                        k_next     = k_inc;
                        idx_next   = idx_adv;
                        state_next = more_steps ? ssng_pkg::S_STEP : ssng_pkg::S_OFF1;
                    end
                end
            end
            ssng_pkg::S_OFF1: begin
                if (!stall) begin
                    if (off_due) begin
                        sounding_next = 1'b0;
                    end
                    state_next = ssng_pkg::S_FINISH;
                end
            end
            ssng_pkg::S_FINISH: begin
                if (can_push) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    if (pend_valid_reg) begin
                        m_tdata_next = {pend_on_reg, pend_pitch_reg};
                        m_tuser_next = ssng_pkg::STATUS_NOTE;
                    end else begin
                        m_tdata_next = '0;
                        m_tuser_next = fin_status_reg;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ssng_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ssng_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ssng_pkg::S_IDLE;
            pend_valid_reg     <= 1'b0;
            sounding_reg       <= 1'b0;
            off_time_reg       <= '0;
            sounding_pitch_reg <= '0;
            prev_valid_reg     <= 1'b0;
            prev_step_reg      <= '0;
            m_tvalid_reg       <= 1'b0;
            ocount_reg         <= '0;
            fin_status_reg     <= ssng_pkg::STATUS_EMPTY;
        end else begin
            state_reg          <= state_next;
            pend_valid_reg     <= pend_valid_next;
            sounding_reg       <= sounding_next;
            off_time_reg       <= off_time_next;
            sounding_pitch_reg <= sounding_pitch_next;
            prev_valid_reg     <= prev_valid_next;
            prev_step_reg      <= prev_step_next;
            m_tvalid_reg       <= m_tvalid_next;
            ocount_reg         <= ocount_next;
            fin_status_reg     <= fin_status_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        bstart_reg     <= bstart_next;
        bend_reg       <= bend_next;
        k_reg          <= k_next;
        lastk_reg      <= lastk_next;
        idx_reg        <= idx_next;
        bit_cnt_reg    <= bit_cnt_next;
        pend_pitch_reg <= pend_pitch_next;
        pend_on_reg    <= pend_on_next;
        m_tdata_reg    <= m_tdata_next;
        m_tlast_reg    <= m_tlast_next;
        m_tuser_reg    <= m_tuser_next;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_mask_reg <= ssng_pkg::PATTERN_MASK_RST;
            note_pitch_reg   <= ssng_pkg::NOTE_PITCH_RST;
            gate_len_reg     <= ssng_pkg::GATE_LEN_RST;
            step_count_reg   <= ssng_pkg::STEP_COUNT_RST;
            max_notes_reg    <= ssng_pkg::MAX_NOTES_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ssng_pkg::REG_PATTERN_MASK: pattern_mask_reg <= cfg_wdata[15:0];
                ssng_pkg::REG_NOTE_PITCH:   note_pitch_reg   <= cfg_wdata[6:0];
                ssng_pkg::REG_GATE_LEN:     gate_len_reg     <= cfg_wdata[8:0];
                ssng_pkg::REG_STEP_COUNT:   step_count_reg   <= cfg_wdata[4:0];
                ssng_pkg::REG_MAX_NOTES:    max_notes_reg    <= cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ssng_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: rtl/core/ssng_checker.sv
// port-level checks of the step sequencer note generator, bound to the top level
module ssng_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a taken item closes the input until its walk is done
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted item");

    // a status result is always the only and final one of its range
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ssng_pkg::STATUS_NOTE) |-> m_tlast)
        else $error("status result without last");

    a_status_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ssng_pkg::STATUS_NOTE) |-> (m_tdata == 8'h00))
        else $error("status result carries note data");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                 && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind step_sequencer_note_gen_core ssng_checker u_ssng_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
